### src/sdf_pkg.sv
package sdf_pkg;

	localparam int VALUE_W        = 16;
	localparam int MAG_W          = 17;
	localparam int CHAR_W         = 8;
	localparam int BCD_W          = 4;
	localparam int DIGITS_DEFAULT = 5;
	// decimal digits of the widest magnitude (32768)
	localparam int MAG_DIGITS     = 5;
	// digit extractions before the ones digit is left over
	localparam int DIV_STEPS      = MAG_DIGITS - 1;
	localparam int QUEUE_DEPTH    = 2;

	typedef logic [MAG_W-1:0]  mag_t;
	typedef logic [BCD_W-1:0]  bcd_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t ASCII_ZERO  = 8'h30;
	localparam char_t ASCII_NINE  = 8'h39;
	localparam char_t ASCII_MINUS = 8'h2D;

	// 2^16, the wrap point for two's complement negation
	localparam mag_t MAG_WRAP = 17'h10000;

	// multiples 0..9 of 10^4, 10^3, 10^2, 10^1
	localparam mag_t MULT_TAB [DIV_STEPS][10] = '{
		'{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
		  17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
		'{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
		  17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
		'{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
		  17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
		'{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
		  17'd50, 17'd60, 17'd70, 17'd80, 17'd90}
	};

	// digits kept for a given digit count, clamped to 1..MAG_DIGITS
	function automatic int keep_digits(int d);
		if (d < 1) return 1;
		if (d > MAG_DIGITS) return MAG_DIGITS;
		return d;
	endfunction

endpackage

### src/sdf_if.sv
interface sdf_num_if;
	import sdf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sdf_char_if;
	import sdf_pkg::*;
	logic  valid;
	logic  ready;
	char_t character;
	logic  last;
	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

### src/signed_decimal_formatter.sv
// Channel  Dir  Payload                            Accepted when
// num      in   value: signed 16-bit               num.valid && num.ready
// text     out  character: 8-bit ASCII, last: 1b   text.valid && text.ready
//
// Front: loads a value, then extracts one digit per cycle over four
//   compare-and-subtract steps, and takes no new value until it pushes. The
//   back emits one character per cycle while text is ready, 1 to 6 per value.
// Path: a value crosses the front, the queue and the output slot in turn.
// Reset: arst_n clears the front, the two-entry queue and the output slot.
// Stalls: the queue lets the front convert the next value while text stalls.
module signed_decimal_formatter #(
	parameter int DIGITS = sdf_pkg::DIGITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	sdf_num_if.sink num,
	sdf_char_if.source text
);
	import sdf_pkg::*;

	localparam int KEEP = keep_digits(DIGITS);
	localparam int QW   = 1 + BCD_W * KEEP;   // sign + kept BCD digits

	// front -> queue
	logic                  f_valid;
	logic                  f_ready;
	logic                  f_neg;
	logic [BCD_W*KEEP-1:0] f_digits;

	// queue -> back
	logic                  b_valid;
	logic                  b_ready;
	logic [QW-1:0]         b_data;

	// classify: sign, magnitude, BCD digits of the magnitude mod 10^KEEP
	sdf_front #(.DIGITS(DIGITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.num         (num),
		.push_valid  (f_valid),
		.push_ready  (f_ready),
		.push_neg    (f_neg),
		.push_digits (f_digits)
	);

	// decouples conversion from character output
	sdf_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_neg, f_digits}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	// serialize: optional '-', then digits with leading zeros dropped
	sdf_back #(.DIGITS(DIGITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_neg    (b_data[QW-1]),
		.pop_digits (b_data[QW-2:0]),
		.text       (text)
	);

endmodule

### src/sdf_front.sv
module sdf_front #(
	parameter int DIGITS = sdf_pkg::DIGITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	sdf_num_if.sink num,
	output logic push_valid,
	input  logic push_ready,
	output logic push_neg,
	output logic [sdf_pkg::BCD_W*sdf_pkg::keep_digits(DIGITS)-1:0] push_digits
);
	import sdf_pkg::*;

	localparam int KEEP   = keep_digits(DIGITS);
	localparam int CNT_W  = $clog2(DIV_STEPS + 1);
	localparam int IDX_W  = $clog2(DIV_STEPS);
	localparam int DIGS_W = BCD_W * DIV_STEPS;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	mag_t              rem_q;
	logic              neg_q;
	logic [DIGS_W-1:0] digs_q;

	logic              accept;
	logic              last_step;
	logic              neg_in;
	logic [VALUE_W-1:0] raw;
	mag_t              mag_in;
	bcd_t              dig;
	mag_t              sub;
	logic [DIGS_W+BCD_W-1:0] full;

	assign raw    = VALUE_W'(num.value);
	assign neg_in = raw[VALUE_W-1];
	assign mag_in = neg_in ? (MAG_WRAP - {1'b0, raw}) : {1'b0, raw};

	assign last_step  = (cnt_q == CNT_W'(DIV_STEPS));
	assign push_valid = busy_q && last_step;
	assign num.ready  = !busy_q || (push_valid && push_ready);
	assign accept     = num.valid && num.ready;

	// one decimal digit per cycle: largest multiple not above the remainder
	always_comb begin
		dig = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem_q >= MULT_TAB[cnt_q[IDX_W-1:0]][k]) dig = bcd_t'(k);
		end
		sub = MULT_TAB[cnt_q[IDX_W-1:0]][dig];
	end

	assign full        = {digs_q, rem_q[BCD_W-1:0]};
	assign push_digits = full[BCD_W*KEEP-1:0];
	assign push_neg    = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (push_valid && push_ready) begin
			busy_q <= 1'b0;
		end else if (busy_q && !last_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= mag_in;
			neg_q <= neg_in;
		end else if (busy_q && !last_step) begin
			rem_q  <= rem_q - sub;
			digs_q <= {digs_q[DIGS_W-BCD_W-1:0], dig};
		end
	end

endmodule

### src/sdf_queue.sv
module sdf_queue #(
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	import sdf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### src/sdf_back.sv
module sdf_back #(
	parameter int DIGITS = sdf_pkg::DIGITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic pop_neg,
	input  logic [sdf_pkg::BCD_W*sdf_pkg::keep_digits(DIGITS)-1:0] pop_digits,
	sdf_char_if.source text
);
	import sdf_pkg::*;

	localparam int KEEP   = keep_digits(DIGITS);
	localparam int DW     = BCD_W * KEEP;
	localparam int LEFT_W = $clog2(KEEP + 1);

	logic              slot_q;
	logic              neg_q;
	logic [LEFT_W-1:0] left_q;
	logic [DW-1:0]     sh_q;

	logic              stop;
	logic [LEFT_W-1:0] lead;
	logic [DW-1:0]     sh_in;
	logic              take;
	logic              fin;
	logic              load;

	// count suppressed leading zeros; the ones digit always stays
	always_comb begin
		lead = '0;
		stop = 1'b0;
		for (int i = 0; i < KEEP - 1; i++) begin
			if (!stop && pop_digits[DW-1-BCD_W*i -: BCD_W] == bcd_t'(0)) lead = lead + LEFT_W'(1);
			else stop = 1'b1;
		end
	end

	assign sh_in = pop_digits << {lead, 2'b00};

	assign text.valid     = slot_q;
	assign text.character = neg_q ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, sh_q[DW-1 -: BCD_W]});
	assign text.last      = !neg_q && (left_q == LEFT_W'(1));

	assign take      = slot_q && text.ready;
	assign fin       = take && text.last;
	assign pop_ready = !slot_q || fin;
	assign load      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 1'b0;
			neg_q  <= 1'b0;
			left_q <= '0;
		end else if (load) begin
			slot_q <= 1'b1;
			neg_q  <= pop_neg;
			left_q <= LEFT_W'(KEEP) - lead;
		end else if (fin) begin
			slot_q <= 1'b0;
		end else if (take) begin
			if (neg_q) neg_q <= 1'b0;
			else left_q <= left_q - LEFT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) sh_q <= sh_in;
		else if (take && !neg_q) sh_q <= sh_q << BCD_W;
	end

endmodule

### src/sdf_checker.sv
module sdf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               num_valid,
	input logic               num_ready,
	input logic               text_valid,
	input logic               text_ready,
	input sdf_pkg::char_t     character,
	input logic               last
);
	import sdf_pkg::*;

	// only '-' or a decimal digit ever appears
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (character == ASCII_MINUS ||
			(character >= ASCII_ZERO && character <= ASCII_NINE)))
		else $error("character outside '-' and '0'..'9'");

	// a sign is always followed by at least one digit
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && character == ASCII_MINUS) |-> !last)
		else $error("'-' marked as last");

	// within a run the next character is ready at once and is a digit
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && text_ready && !last) |=> (text_valid && character != ASCII_MINUS))
		else $error("gap or second '-' inside a run");

	// stalled item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && !text_ready) |=> (text_valid && $stable(character) && $stable(last)))
		else $error("text item changed while stalled");

	// a value in conversion blocks the next one in the cycle after it is accepted
	a_num_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(num_valid && num_ready) |=> !num_ready)
		else $error("value accepted while previous one still converting");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.num_valid  (num.valid),
	.num_ready  (num.ready),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.character  (text.character),
	.last       (text.last)
);
